@@ src/circular_run_queue_with_remove_assert.svh @@
// ----------------------------------------------------------------------------
// run queue assertion macros
// immediate-consequence and next-cycle property forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_RUN_QUEUE_WITH_REMOVE_ASSERT_SVH
`define CIRCULAR_RUN_QUEUE_WITH_REMOVE_ASSERT_SVH

// same-cycle implication
`define CRQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("run queue check failed");

// next-cycle implication
`define CRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("run queue check failed");

`endif

@@ src/crq_pkg.sv @@
// ----------------------------------------------------------------------------
// crq_pkg
// shared request, result and controller types for the run queue
// ----------------------------------------------------------------------------
package crq_pkg;

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_FIND   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RES_DONE      = 2'd0,
    RES_FULL      = 2'd1,
    RES_EMPTY     = 2'd2,
    RES_NOT_FOUND = 2'd3
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DEQ,
    S_SCAN,
    S_SHIFT,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic  latch_req;
    logic  cfg_write;
    logic  enq;
    logic  deq_read;
    logic  deq_take;
    logic  scan_start;
    logic  scan_adv;
    logic  scan_miss;
    logic  scan_hit;
    logic  shift_move;
    logic  remove_done;
    logic  set_res;
    res_t  res_code;
    logic  push_out;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  hit;
    logic  last;
    logic  more;
    logic  out_free;
  } stat_t;

endpackage

@@ src/circular_run_queue_with_remove.sv @@
// ----------------------------------------------------------------------------
// circular_run_queue_with_remove
// circular queue of process ids with enqueue, dequeue, find and remove
// ----------------------------------------------------------------------------
//  channel | signals                               | word
//  in      | in_valid, in_stall                    | mode, new_id, key_id
//  out     | out_valid, out_stall                  | status, result_id, occupancy,
//          |                                       | is_empty, is_full
//  cfg     | cfg_valid, cfg_ready                  | cfg_data (queue capacity)
//
//  one word at a time; enqueue and rejected requests go from decode straight to reply,
//  dequeue adds a read step, find scans from the head up to the match, remove
//  also shifts the later entries over the match, and a search miss scans every
//  entry held; one slot memory read or slot move per cycle in scan and shift
//  reset and a capacity write empty the queue; capacity resets to 64
//  a new word is taken while the previous result waits; a stalled result
//  holds the sequencer in its reply step
// ----------------------------------------------------------------------------
module circular_run_queue_with_remove #(
  parameter int MAX_SLOTS = 64,
  parameter int ID_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] new_id,
  input  logic [15:0] key_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] result_id,
  output logic [6:0]  occupancy,
  output logic        is_empty,
  output logic        is_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  crq_pkg::cmd_t  cmd;
  crq_pkg::stat_t stat;

  crq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  crq_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .ID_BITS   (ID_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .new_id    (new_id),
    .key_id    (key_id),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .result_id (result_id),
    .occupancy (occupancy),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

endmodule

@@ src/crq_ctrl.sv @@
// ----------------------------------------------------------------------------
// crq_ctrl
// request sequencer: decode, dequeue, scan, shift and reply steps
// ----------------------------------------------------------------------------
module crq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  crq_pkg::stat_t stat,
  output crq_pkg::cmd_t  cmd
);

  crq_pkg::state_t state;
  crq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      crq_pkg::S_IDLE: begin
        if (!cfg_valid && in_valid) begin
          state_next = crq_pkg::S_DECIDE;
        end
      end
      crq_pkg::S_DECIDE: begin
        if (stat.mode == crq_pkg::MODE_ENQ || stat.empty) begin
          state_next = crq_pkg::S_REPLY;
        end else if (stat.mode == crq_pkg::MODE_DEQ) begin
          state_next = crq_pkg::S_DEQ;
        end else begin
          state_next = crq_pkg::S_SCAN;
        end
      end
      crq_pkg::S_DEQ: begin
        state_next = crq_pkg::S_REPLY;
      end
      crq_pkg::S_SCAN: begin
        if (stat.hit) begin
          state_next = (stat.mode == crq_pkg::MODE_FIND) ? crq_pkg::S_REPLY : crq_pkg::S_SHIFT;
        end else if (stat.last) begin
          state_next = crq_pkg::S_REPLY;
        end
      end
      crq_pkg::S_SHIFT: begin
        if (!stat.more) begin
          state_next = crq_pkg::S_REPLY;
        end
      end
      crq_pkg::S_REPLY: begin
        if (stat.out_free) begin
          state_next = crq_pkg::S_IDLE;
        end
      end
      default: state_next = crq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cfg_ready = 1'b0;
    in_stall  = 1'b1;
    case (state)
      crq_pkg::S_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
        end else if (in_valid) begin
          cmd.latch_req = 1'b1;
        end
      end
      crq_pkg::S_DECIDE: begin
        cmd.set_res = 1'b1;
        if (stat.mode == crq_pkg::MODE_ENQ) begin
          if (stat.full) begin
            cmd.res_code = crq_pkg::RES_FULL;
          end else begin
            cmd.res_code = crq_pkg::RES_DONE;
            cmd.enq      = 1'b1;
          end
        end else if (stat.empty) begin
          cmd.res_code = crq_pkg::RES_EMPTY;
        end else if (stat.mode == crq_pkg::MODE_DEQ) begin
          cmd.set_res  = 1'b0;
          cmd.deq_read = 1'b1;
        end else begin
          cmd.set_res    = 1'b0;
          cmd.scan_start = 1'b1;
        end
      end
      crq_pkg::S_DEQ: begin
        cmd.deq_take = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = crq_pkg::RES_DONE;
      end
      crq_pkg::S_SCAN: begin
        cmd.scan_adv = 1'b1;
        if (stat.hit) begin
          cmd.scan_hit = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = crq_pkg::RES_DONE;
        end else if (stat.last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = crq_pkg::RES_NOT_FOUND;
        end else begin
          cmd.scan_miss = 1'b1;
        end
      end
      crq_pkg::S_SHIFT: begin
        if (stat.more) begin
          cmd.shift_move = 1'b1;
          cmd.scan_adv   = 1'b1;
        end else begin
          cmd.remove_done = 1'b1;
        end
      end
      crq_pkg::S_REPLY: begin
        cmd.push_out = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ src/crq_datapath.sv @@
// ----------------------------------------------------------------------------
// crq_datapath
// slot memory, queue indices, scan pointers and result register
// ----------------------------------------------------------------------------
module crq_datapath #(
  parameter int MAX_SLOTS = 64,
  parameter int ID_BITS   = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  crq_pkg::cmd_t  cmd,
  output crq_pkg::stat_t stat,
  input  logic [6:0]     cfg_data,
  input  logic [1:0]     mode,
  input  logic [15:0]    new_id,
  input  logic [15:0]    key_id,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     status,
  output logic [15:0]    result_id,
  output logic [6:0]     occupancy,
  output logic           is_empty,
  output logic           is_full
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = ((AW > 7) ? AW : 7) + 1;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx, input logic [6:0] cap);
    logic [CW-1:0] s;
    s = CW'(idx) + CW'(1);
    return (s >= CW'(cap)) ? '0 : s[AW-1:0];
  endfunction

  logic [ID_BITS-1:0]  mem [MAX_SLOTS];
  logic [ID_BITS-1:0]  rdata;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ID_BITS-1:0]  mem_wdata;
  logic [AW-1:0]       mem_raddr;

  logic [6:0]          cap_cfg;
  logic [6:0]          cap_eff;
  logic [AW-1:0]       rd;
  logic [AW-1:0]       wr;
  logic [6:0]          cnt;
  logic [AW-1:0]       ptr;
  logic [AW-1:0]       cur;
  logic [6:0]          k;

  crq_pkg::mode_t      req_mode;
  logic [ID_BITS-1:0]  req_new;
  logic [ID_BITS-1:0]  req_key;
  crq_pkg::res_t       res_code;
  logic [ID_BITS-1:0]  res_id;

  logic [ID_BITS+15:0] new_ext;
  logic [ID_BITS+15:0] key_ext;
  logic [ID_BITS+15:0] res_ext;

  assign new_ext = {{ID_BITS{1'b0}}, new_id};
  assign key_ext = {{ID_BITS{1'b0}}, key_id};
  assign res_ext = {16'h0000, res_id};

  always_comb begin
    if (cap_cfg == 7'd0) begin
      cap_eff = 7'd1;
    end else if (32'(cap_cfg) > 32'(MAX_SLOTS)) begin
      cap_eff = 7'(MAX_SLOTS);
    end else begin
      cap_eff = cap_cfg;
    end
  end

  assign mem_we    = cmd.enq | cmd.shift_move;
  assign mem_waddr = cmd.enq ? wr : cur;
  assign mem_wdata = cmd.enq ? req_new : rdata;
  assign mem_raddr = (cmd.deq_read | cmd.scan_start) ? rd : ptr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  assign stat.mode     = req_mode;
  assign stat.full     = (cnt >= cap_eff);
  assign stat.empty    = (cnt == 7'd0);
  assign stat.hit      = (rdata == req_key);
  assign stat.last     = (k == cnt - 7'd1);
  assign stat.more     = (k < cnt);
  assign stat.out_free = !out_valid || !out_stall;

  // queue indices and count
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_cfg <= 7'd64;
      rd      <= '0;
      wr      <= '0;
      cnt     <= '0;
    end else if (cmd.cfg_write) begin
      cap_cfg <= cfg_data;
      rd      <= '0;
      wr      <= '0;
      cnt     <= '0;
    end else begin
      if (cmd.enq) begin
        wr  <= wrap_inc(wr, cap_eff);
        cnt <= cnt + 7'd1;
      end
      if (cmd.deq_take) begin
        rd  <= wrap_inc(rd, cap_eff);
        cnt <= cnt - 7'd1;
      end
      if (cmd.remove_done) begin
        wr  <= (wr == '0) ? AW'(cap_eff - 7'd1) : wr - AW'(1);
        cnt <= cnt - 7'd1;
      end
    end
  end

  // request, scan and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_mode <= crq_pkg::mode_t'(mode);
      req_new  <= new_ext[ID_BITS-1:0];
      req_key  <= key_ext[ID_BITS-1:0];
      res_id   <= '0;
    end
    if (cmd.scan_start) begin
      ptr <= wrap_inc(rd, cap_eff);
      cur <= rd;
      k   <= '0;
    end
    if (cmd.scan_adv) begin
      ptr <= wrap_inc(ptr, cap_eff);
    end
    if (cmd.scan_miss || cmd.shift_move) begin
      cur <= wrap_inc(cur, cap_eff);
      k   <= k + 7'd1;
    end
    if (cmd.scan_hit) begin
      res_id <= rdata;
      k      <= k + 7'd1;
    end
    if (cmd.deq_take) begin
      res_id <= rdata;
    end
    if (cmd.set_res) begin
      res_code <= cmd.res_code;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_out) begin
      status    <= res_code;
      result_id <= res_ext[15:0];
      occupancy <= cnt;
      is_empty  <= (cnt == 7'd0);
      is_full   <= (cnt == cap_eff);
    end
  end

endmodule

@@ src/crq_checker.sv @@
// ----------------------------------------------------------------------------
// crq_checker
// port-level checks on the run queue, bound to the top level
// ----------------------------------------------------------------------------
`include "circular_run_queue_with_remove_assert.svh"

module crq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [15:0] result_id,
  input logic [6:0]  occupancy,
  input logic        is_empty,
  input logic        is_full
);

  `CRQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_id) && $stable(status))
  `CRQ_ASSERT_NOW(a_empty_flag, out_valid, is_empty == (occupancy == 7'd0))
  `CRQ_ASSERT_NOW(a_reject_zero, out_valid && status != crq_pkg::RES_DONE, result_id == 16'h0000)
  `CRQ_ASSERT_NOW(a_full_not_empty, out_valid && is_full, !is_empty)
  `CRQ_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

endmodule

bind circular_run_queue_with_remove crq_checker u_crq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .result_id (result_id),
  .occupancy (occupancy),
  .is_empty  (is_empty),
  .is_full   (is_full)
);
